FILE: design/crx_pkg.sv
// Shared types, character constants and the character classifier for the
// range expander. No dependencies.
package crx_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_LOWER,
        CLS_UPPER,
        CLS_DIGIT
    } t_class;

    // One command handed from the front to the back: the results that one
    // input beat causes, in emission order dash, range, character, terminator.
    typedef struct packed {
        logic       do_dash;
        logic       do_range;
        logic       down;
        logic [7:0] start;
        logic [7:0] stop;
        logic       do_char;
        logic [7:0] chr;
        logic       do_term;
    } t_cmd;

    function automatic t_class char_class(input logic [7:0] c);
        t_class k;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            k = CLS_LOWER;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            k = CLS_UPPER;
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            k = CLS_DIGIT;
        end else begin
            k = CLS_NONE;
        end
        return k;
    endfunction

endpackage

FILE: design/crx_front.sv
// Front end: accepts input beats, holds the dash lookahead state and turns
// each beat into at most one command. Depends on crx_pkg.
module crx_front
    import crx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_q_ready
);

    logic [7:0] r_prev;
    logic       r_have_prev;
    logic       r_dash_pending;
    logic [7:0] n_prev;
    logic       n_have_prev;
    logic       n_dash_pending;

    logic   accept;
    logic   match;
    logic   have_prev_mid;
    logic   hold;
    t_class k_prev;
    t_class k_char;
    t_cmd   cmd;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        k_prev = char_class(r_prev);
        k_char = char_class(i_in_char);
        match  = r_dash_pending && r_have_prev && (k_prev != CLS_NONE) && (k_prev == k_char);
        // Once a held dash is resolved, something always precedes the new character.
        have_prev_mid = r_have_prev || r_dash_pending;
        hold = !match && (i_in_char == CH_DASH) && !i_in_last && have_prev_mid;

        cmd.do_dash  = r_dash_pending && !match;
        cmd.do_range = match && (r_prev != i_in_char);
        cmd.down     = r_prev > i_in_char;
        cmd.start    = (r_prev > i_in_char) ? r_prev - 8'd1 : r_prev + 8'd1;
        cmd.stop     = i_in_char;
        cmd.do_char  = !match && !hold;
        cmd.chr      = i_in_char;
        cmd.do_term  = i_in_last;

        n_prev         = r_prev;
        n_have_prev    = r_have_prev;
        n_dash_pending = r_dash_pending;
        if (accept) begin
            if (i_in_last) begin
                n_prev         = CH_NUL;
                n_have_prev    = 1'b0;
                n_dash_pending = 1'b0;
            end else begin
                n_dash_pending = hold;
                n_have_prev    = have_prev_mid || cmd.do_char;
                if (match || cmd.do_char) begin
                    n_prev = i_in_char;
                end else if (cmd.do_dash) begin
                    n_prev = CH_DASH;
                end
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.do_dash || cmd.do_range || cmd.do_char || cmd.do_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev         <= CH_NUL;
            r_have_prev    <= 1'b0;
            r_dash_pending <= 1'b0;
        end else begin
            r_prev         <= n_prev;
            r_have_prev    <= n_have_prev;
            r_dash_pending <= n_dash_pending;
        end
    end

endmodule

FILE: design/crx_queue.sv
// Short command queue between the front and the back end.
// Depends on crx_pkg for the command type.
module crx_queue
    import crx_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_cmd          r_slots [P_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    logic do_push;
    logic do_pop;

    assign o_ready = r_count != FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slots[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

FILE: design/crx_back.sv
// Back end: takes one command at a time from the queue and emits its results, one per
// cycle unless the output stalls, through an output register. Depends on crx_pkg.
module crx_back
    import crx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_end_of_string,
    output logic       o_run_last
);

    logic       r_busy;
    logic       r_do_dash;
    logic       r_do_range;
    logic       r_do_char;
    logic       r_do_term;
    logic       r_down;
    logic [7:0] r_cur;
    logic [7:0] r_stop;
    logic [7:0] r_chr;
    logic       r_ov;
    logic [7:0] r_oc;
    logic       r_oeos;
    logic       r_olast;

    logic       n_busy;
    logic       n_do_dash;
    logic       n_do_range;
    logic       n_do_char;
    logic       n_do_term;
    logic       n_down;
    logic [7:0] n_cur;
    logic [7:0] n_stop;
    logic [7:0] n_chr;
    logic       n_ov;
    logic [7:0] n_oc;
    logic       n_oeos;
    logic       n_olast;

    logic load;
    logic emit;

    assign load  = !r_busy && i_q_valid;
    assign emit  = r_busy && (!r_ov || i_ready);
    assign o_pop = load;

    always_comb begin
        n_busy     = r_busy;
        n_do_dash  = r_do_dash;
        n_do_range = r_do_range;
        n_do_char  = r_do_char;
        n_do_term  = r_do_term;
        n_down     = r_down;
        n_cur      = r_cur;
        n_stop     = r_stop;
        n_chr      = r_chr;
        n_ov       = r_ov && !i_ready;
        n_oc       = r_oc;
        n_oeos     = r_oeos;
        n_olast    = r_olast;

        if (load) begin
            n_busy     = 1'b1;
            n_do_dash  = i_cmd.do_dash;
            n_do_range = i_cmd.do_range;
            n_do_char  = i_cmd.do_char;
            n_do_term  = i_cmd.do_term;
            n_down     = i_cmd.down;
            n_cur      = i_cmd.start;
            n_stop     = i_cmd.stop;
            n_chr      = i_cmd.chr;
        end else if (emit) begin
            n_ov   = 1'b1;
            n_oeos = 1'b0;
            // Priority follows emission order; the remaining flags decide run_last.
            if (r_do_dash) begin
                n_oc      = CH_DASH;
                n_do_dash = 1'b0;
                n_busy    = r_do_range || r_do_char || r_do_term;
            end else if (r_do_range) begin
                n_oc = r_cur;
                if (r_cur == r_stop) begin
                    n_do_range = 1'b0;
                    n_busy     = r_do_char || r_do_term;
                end else begin
                    n_cur  = r_down ? r_cur - 8'd1 : r_cur + 8'd1;
                    n_busy = 1'b1;
                end
            end else if (r_do_char) begin
                n_oc      = r_chr;
                n_do_char = 1'b0;
                n_busy    = r_do_term;
            end else begin
                n_oc      = CH_NUL;
                n_oeos    = 1'b1;
                n_do_term = 1'b0;
                n_busy    = 1'b0;
            end
            n_olast = !n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_ov       <= 1'b0;
            r_do_dash  <= 1'b0;
            r_do_range <= 1'b0;
            r_do_char  <= 1'b0;
            r_do_term  <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_ov       <= n_ov;
            r_do_dash  <= n_do_dash;
            r_do_range <= n_do_range;
            r_do_char  <= n_do_char;
            r_do_term  <= n_do_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_down  <= n_down;
        r_cur   <= n_cur;
        r_stop  <= n_stop;
        r_chr   <= n_chr;
        r_oc    <= n_oc;
        r_oeos  <= n_oeos;
        r_olast <= n_olast;
    end

    assign o_valid         = r_ov;
    assign o_out_char      = r_oc;
    assign o_end_of_string = r_oeos;
    assign o_run_last      = r_olast;

endmodule

FILE: design/char_range_expander.sv
// Channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | i_valid / o_ready   | i_in_char[7:0], i_in_last
// output   | o_valid / i_ready   | o_out_char[7:0], o_end_of_string, o_run_last
//
// Top level of the shorthand range expander: front end, command queue and back
// end. Depends on crx_pkg, crx_front, crx_queue and crx_back.
// The front end takes one input beat per cycle while the queue has room.
// The back end loads a command, then emits its results one per cycle while the
// output is not stalled, and loads no new command until it has emitted all of them.
// Reset is synchronous and clears the lookahead state, the queue and the
// output valid flag. Either side may stall without losing beats.
module char_range_expander
    import crx_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_end_of_string,
    output logic       o_run_last
);

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    crx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_char (i_in_char),
        .i_in_last (i_in_last),
        .o_push    (push),
        .o_cmd     (f_cmd),
        .i_q_ready (q_ready)
    );

    crx_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    crx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_end_of_string (o_end_of_string),
        .o_run_last      (o_run_last)
    );

endmodule

FILE: verif/char_range_expander_tb.sv
// Self-checking testbench for char_range_expander: directed strings, then random
// strings with dash ranges, under random idling on both sides and a long output stall.
// Depends on crx_pkg and the char_range_expander RTL.
module char_range_expander_tb;
    import crx_pkg::*;

    localparam int RANDOM_ITEMS   = 185;
    localparam int NO_IDLE_ITEMS  = 70;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [7:0] chr;
        logic       eos;
        logic       run_last;
    } t_exp_result;

    // Tracks the lookahead state of the expander and holds the characters that
    // the output side still owes.
    class expansion_scoreboard;
        t_exp_result expected[$];
        logic [7:0]  last_char;
        bit          has_last;
        bit          dash_held;
        int          errors;
        int          beats;
        int          results;
        int          ranges;
        int          literal_dashes;
        int          strings_done;

        function new();
            last_char      = CH_NUL;
            has_last       = 1'b0;
            dash_held      = 1'b0;
            errors         = 0;
            beats          = 0;
            results        = 0;
            ranges         = 0;
            literal_dashes = 0;
            strings_done   = 0;
        endfunction

        function t_class classify(logic [7:0] c);
            t_class k;
            k = CLS_NONE;
            if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
                k = CLS_DIGIT;
            end
            if (c >= CH_UP_A && c <= CH_UP_Z) begin
                k = CLS_UPPER;
            end
            if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
                k = CLS_LOWER;
            end
            return k;
        endfunction

        function t_exp_result char_result(logic [7:0] c, logic eos);
            t_exp_result r;
            r.chr      = c;
            r.eos      = eos;
            r.run_last = 1'b0;
            return r;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
        endtask

        // Works out the characters that one input beat releases.
        function void expand_beat(logic [7:0] c, logic last);
            t_exp_result batch[$];
            t_exp_result r;
            t_class      k;
            bit          consumed;
            int          v;
            consumed = 1'b0;
            beats++;
            if (dash_held) begin
                dash_held = 1'b0;
                k = classify(last_char);
                if (has_last && k != CLS_NONE && k == classify(c)) begin
                    if (last_char <= c) begin
                        for (v = int'(last_char) + 1; v <= int'(c); v++) begin
                            batch.push_back(char_result(v[7:0], 1'b0));
                        end
                    end else begin
                        for (v = int'(last_char) - 1; v >= int'(c); v--) begin
                            batch.push_back(char_result(v[7:0], 1'b0));
                        end
                    end
                    last_char = c;
                    has_last  = 1'b1;
                    consumed  = 1'b1;
                    ranges++;
                end else begin
                    batch.push_back(char_result(CH_DASH, 1'b0));
                    last_char = CH_DASH;
                    has_last  = 1'b1;
                    literal_dashes++;
                end
            end
            if (!consumed) begin
                if (c == CH_DASH && !last && has_last) begin
                    dash_held = 1'b1;
                end else begin
                    batch.push_back(char_result(c, 1'b0));
                    if (c == CH_DASH) begin
                        literal_dashes++;
                    end
                    last_char = c;
                    has_last  = 1'b1;
                end
            end
            if (last) begin
                batch.push_back(char_result(CH_NUL, 1'b1));
                last_char = CH_NUL;
                has_last  = 1'b0;
                dash_held = 1'b0;
                strings_done++;
            end
            if (batch.size() > 0) begin
                r = batch.pop_back();
                r.run_last = 1'b1;
                batch.push_back(r);
                foreach (batch[i]) begin
                    expected.push_back(batch[i]);
                end
            end
        endfunction

        task check_result(logic [7:0] c, logic eos, logic rl);
            t_exp_result want;
            results++;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("unexpected beat char %02h eos %b run_last %b",
                                          c, eos, rl));
                return;
            end
            want = expected.pop_front();
            if (c !== want.chr) begin
                report_mismatch($sformatf("char %02h, expected %02h", c, want.chr));
            end
            if (eos !== want.eos) begin
                report_mismatch($sformatf("end_of_string %b, expected %b (char %02h)",
                                          eos, want.eos, want.chr));
            end
            if (rl !== want.run_last) begin
                report_mismatch($sformatf("run_last %b, expected %b (char %02h)",
                                          rl, want.run_last, want.chr));
            end
        endtask
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_char = 8'h00;
    logic       i_in_last = 1'b0;
    logic       o_valid;
    logic       i_ready   = 1'b0;
    logic [7:0] o_out_char;
    logic       o_end_of_string;
    logic       o_run_last;

    expansion_scoreboard sb;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    char_range_expander u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_char       (i_in_char),
        .i_in_last       (i_in_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_end_of_string (o_end_of_string),
        .o_run_last      (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = RX_HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= rx_idle_en ? ($urandom_range(0, 99) >= 25) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_out_char, o_end_of_string, o_run_last);
        end
    end

    function automatic logic [7:0] class_char(t_class k);
        logic [7:0] c;
        case (k)
            CLS_LOWER: c = CH_LOW_A + 8'($urandom_range(0, 25));
            CLS_UPPER: c = CH_UP_A + 8'($urandom_range(0, 25));
            CLS_DIGIT: c = CH_DIG_0 + 8'($urandom_range(0, 9));
            default:   c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // Valid is left high after a beat; the next call or the caller lowers it
    // in the same time step if no beat follows.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (tx_idle_en && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_char <= c;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        sb.expand_beat(c, last);
    endtask

    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i]) begin
            send_char(s[i], i == s.size() - 1);
        end
    endtask

    task automatic send_text(input string t);
        logic [7:0] s[$];
        for (int i = 0; i < t.len(); i++) begin
            s.push_back(t[i]);
        end
        send_string(s);
    endtask

    initial begin
        logic [7:0] text[$];
        t_class     k;
        int         random_items;
        int         strings;
        int         ntok;
        int         sel;
        int         waited;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading dash, ranges both ways, trailing dash, mismatched ends,
        // a dash after a broken range, equal ends.
        send_text("-a-e");
        send_text("Z-A");
        send_text("9-0x-");
        send_text("a-Z");
        send_text("q--b");
        send_text("m-m");
        // Zero byte and the byte extremes.
        text = '{8'h00, 8'hFF, 8'h01, 8'h80};
        send_string(text);

        random_items = 0;
        strings      = 0;
        while (random_items < RANDOM_ITEMS) begin
            tx_idle_en = (random_items >= NO_IDLE_ITEMS);
            rx_idle_en = (random_items >= NO_IDLE_ITEMS);
            if (strings == 3) begin
                hold_requests++;
            end
            if (strings == 14) begin
                i_valid <= 1'b0;
                while (sb.expected.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            text.delete();
            ntok = $urandom_range(1, 6);
            repeat (ntok) begin
                sel = $urandom_range(0, 99);
                k   = t_class'($urandom_range(1, 3));
                if (sel < 40) begin
                    text.push_back(class_char(k));
                    text.push_back(CH_DASH);
                    text.push_back(class_char(k));
                end else if (sel < 52 && text.size() > 0
                             && sb.classify(text[text.size() - 1]) != CLS_NONE) begin
                    // Chain a further range onto the end of the previous one.
                    k = sb.classify(text[text.size() - 1]);
                    text.push_back(CH_DASH);
                    text.push_back(class_char(k));
                end else if (sel < 70) begin
                    text.push_back(8'($urandom_range(1, 255)));
                end else if (sel < 80) begin
                    text.push_back(class_char(k));
                end else if (sel < 90) begin
                    text.push_back(class_char(k));
                    text.push_back(CH_DASH);
                    text.push_back(($urandom_range(0, 1) == 1)
                                   ? class_char(t_class'((int'(k) % 3) + 1))
                                   : 8'($urandom_range(1, 255)));
                end else if (sel < 96) begin
                    text.push_back(CH_DASH);
                end else begin
                    text.push_back(CH_DASH);
                    text.push_back(CH_DASH);
                end
            end
            send_string(text);
            random_items += text.size();
            strings++;
        end
        i_valid <= 1'b0;

        waited = 0;
        while (sb.expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.expected.size() != 0) begin
            sb.report_mismatch($sformatf("%0d expected beats never arrived",
                                         sb.expected.size()));
        end

        $display("Run covered %0d input beats in %0d strings and checked %0d output beats.",
                 sb.beats, sb.strings_done, sb.results);
        $display("It expanded %0d ranges and passed %0d dashes through literally.",
                 sb.ranges, sb.literal_dashes);
        if (sb.errors == 0) begin
            $display("** char_range_expander: PASSED **");
        end else begin
            $display("** char_range_expander: FAILED **");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Run timed out.");
        $display("** char_range_expander: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/crx_pkg.sv
design/crx_front.sv
design/crx_queue.sv
design/crx_back.sv
design/char_range_expander.sv
verif/char_range_expander_tb.sv
